>>> rtl/lrr_pkg.sv
// shared constants and types for the lehmer random range generator
`timescale 1ns / 1ps

package lrr_pkg;

  // stream widths
  localparam int unsigned DataW  = 64;
  localparam int unsigned WordW  = 32;
  localparam int unsigned ScaleW = 31;

  // generator constants, modulus is the prime 2^32 - 5
  localparam logic [WordW-1:0] LehmerMult  = 32'd1588635695;
  localparam logic [WordW-1:0] LehmerMod   = 32'd4294967291;
  localparam logic [WordW-1:0] LehmerReset = 32'd93186752;

  // one multiplier bit per cycle over a full word
  localparam int unsigned Steps = WordW;
  localparam int unsigned CntW  = $clog2(Steps);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_DONE
  } lrr_state_e;

  typedef enum logic {
    MODE_DRAW   = 1'b0,
    MODE_RESEED = 1'b1
  } lrr_mode_e;

  typedef enum logic {
    STATUS_OK     = 1'b0,
    STATUS_REJECT = 1'b1
  } lrr_status_e;

endpackage

>>> rtl/lehmer_random_range.sv
// lehmer random range generator: bit-serial modular multiply and scaling
`timescale 1ns / 1ps
//
// Requests arrive on the s_axis channel: tuser carries the mode (draw or
// reseed), tdata carries the seed and the largest value of the scaled draw.
// Each request gives exactly one result on the m_axis channel: the state
// after the request, the scaled draw and, on tuser, the reject flag.
// A reseed is answered in the cycle after it is taken.
// A draw goes through one shared shift-add unit twice, one multiplier bit
// per cycle: first for the modular product with the fixed multiplier,
// then for state * (range_max + 1) divided by the modulus; the result is
// then moved to the output register once that register is free, and the
// next request is taken only after that.
// The block works on one request at a time and takes a new one only when
// the output register is empty or being emptied in the same cycle.
// Reset sets the state to 93186752 and empties the output register.
// A stalled receiver holds the result in the output register, and the
// input side stays not ready until that result has been taken.
//
module lehmer_random_range (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // seed_value [31:0], range_max [62:32], zero [63]
  input  logic [lrr_pkg::DataW-1:0] s_axis_tdata,
  // mode [0]
  input  logic                     s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // state_value [31:0], scaled_value [62:32], zero [63]
  output logic [lrr_pkg::DataW-1:0] m_axis_tdata,
  // status [0]
  output logic                     m_axis_tuser
);
  import lrr_pkg::*;

  lrr_state_e        st_q, st_d;
  logic [WordW-1:0]  gen_q, gen_d;
  logic [WordW-1:0]  acc_q, acc_d;
  logic [ScaleW-1:0] quo_q, quo_d;
  logic [WordW-1:0]  mult_q, mult_d;
  logic [WordW-1:0]  span_q, span_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [WordW-1:0]  out_state_q, out_state_d;
  logic [ScaleW-1:0] out_scaled_q, out_scaled_d;
  lrr_status_e       out_status_q, out_status_d;

  logic [WordW+1:0]  step_sum;
  logic [WordW+1:0]  step_sub;
  logic [WordW+1:0]  step_diff;
  logic [1:0]        step_k;
  logic [WordW-1:0]  step_rem;
  logic [WordW-1:0]  quo_wide;
  logic [ScaleW-1:0] quo_next;
  logic              step_last;

  logic [WordW-1:0]  in_seed;
  logic [ScaleW-1:0] in_max;
  lrr_mode_e         in_mode;
  logic              seed_ok;
  logic              out_free;
  logic              in_take;

  // input fields
  assign in_seed = s_axis_tdata[WordW-1:0];
  assign in_max  = s_axis_tdata[WordW+ScaleW-1:WordW];
  assign in_mode = lrr_mode_e'(s_axis_tuser);
  assign seed_ok = (in_seed != '0) && (in_seed < LehmerMod);

  // one shift-add step: t = 2r + bit * x, keep t mod p, quotient digit k
  always_comb begin
    step_sum = {1'b0, acc_q, 1'b0} + (mult_q[WordW-1] ? {2'b00, gen_q} : '0);
    if (step_sum >= {1'b0, LehmerMod, 1'b0}) begin
      step_k   = 2'd2;
      step_sub = {1'b0, LehmerMod, 1'b0};
    end else if (step_sum >= {2'b00, LehmerMod}) begin
      step_k   = 2'd1;
      step_sub = {2'b00, LehmerMod};
    end else begin
      step_k   = 2'd0;
      step_sub = '0;
    end
    step_diff = step_sum - step_sub;
    step_rem  = step_diff[WordW-1:0];
    quo_wide  = {quo_q, 1'b0} + {{(WordW-2){1'b0}}, step_k};
    quo_next  = quo_wide[ScaleW-1:0];
  end

  // request taken in idle when the output register is free
  assign step_last = (cnt_q == CntW'(Steps - 1));
  assign out_free  = !out_valid_q || m_axis_tready;
  assign in_take   = s_axis_tvalid && out_free;

  // next state and outputs
  always_comb begin
    st_d         = st_q;
    gen_d        = gen_q;
    acc_d        = acc_q;
    quo_d        = quo_q;
    mult_d       = mult_q;
    span_d       = span_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_state_d  = out_state_q;
    out_scaled_d = out_scaled_q;
    out_status_d = out_status_q;
    s_axis_tready = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        s_axis_tready = out_free;
        if (in_take) begin
          if (in_mode == MODE_RESEED) begin
            out_valid_d  = 1'b1;
            out_scaled_d = '0;
            if (seed_ok) begin
              gen_d        = in_seed;
              out_state_d  = in_seed;
              out_status_d = STATUS_OK;
            end else begin
              out_state_d  = gen_q;
              out_status_d = STATUS_REJECT;
            end
          end else begin
            mult_d = LehmerMult;
            acc_d  = '0;
            quo_d  = '0;
            cnt_d  = '0;
            span_d = {1'b0, in_max} + WordW'(1);
            st_d   = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        acc_d  = step_rem;
        mult_d = {mult_q[WordW-2:0], 1'b0};
        cnt_d  = cnt_q + CntW'(1);
        if (step_last) begin
          gen_d  = step_rem;
          acc_d  = '0;
          quo_d  = '0;
          mult_d = span_q;
          cnt_d  = '0;
          st_d   = ST_SCALE;
        end
      end
      ST_SCALE: begin
        acc_d  = step_rem;
        quo_d  = quo_next;
        mult_d = {mult_q[WordW-2:0], 1'b0};
        cnt_d  = cnt_q + CntW'(1);
        if (step_last) begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_state_d  = gen_q;
          out_scaled_d = quo_q;
          out_status_d = STATUS_OK;
          st_d         = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      gen_q       <= LehmerReset;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      gen_q       <= gen_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // serial datapath and result payload
  always_ff @(posedge clk_i) begin
    acc_q        <= acc_d;
    quo_q        <= quo_d;
    mult_q       <= mult_d;
    span_q       <= span_d;
    out_state_q  <= out_state_d;
    out_scaled_q <= out_scaled_d;
    out_status_q <= out_status_d;
  end

  // result channel
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_scaled_q, out_state_q};
  assign m_axis_tuser  = out_status_q;

endmodule

>>> rtl/lrr_checker.sv
// port-level checks for the lehmer random range generator
`timescale 1ns / 1ps

module lrr_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [lrr_pkg::DataW-1:0] s_axis_tdata,
  input logic                      s_axis_tuser,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [lrr_pkg::DataW-1:0] m_axis_tdata,
  input logic                      m_axis_tuser
);
  import lrr_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // a request is only taken when the output register can take its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
    else $error("request taken while result blocked");

  // the state shown always lies from 1 to modulus - 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[WordW-1:0] != '0)
      && (m_axis_tdata[WordW-1:0] < LehmerMod))
    else $error("state out of range");

  // a rejected reseed carries a zero scaled value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[WordW+ScaleW-1:WordW] == '0)
    else $error("rejected reseed with nonzero scaled value");

  // a reseed request with a usable seed is answered with that seed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser
      && (s_axis_tdata[WordW-1:0] != '0) && (s_axis_tdata[WordW-1:0] < LehmerMod)
      |=> m_axis_tvalid && !m_axis_tuser
      && (m_axis_tdata[WordW-1:0] == $past(s_axis_tdata[WordW-1:0])))
    else $error("reseed not answered with seed");

endmodule

bind lehmer_random_range lrr_checker u_lrr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
